// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MRQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define MRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define MRQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/mrq_pkg.sv -----
// types, codes and constant tables of the mouse report to quadrature unit
package mrq_pkg;

	localparam logic CMD_REPORT = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	localparam logic [2:0] BUTTON_RESET  = 3'h7;
	localparam logic [1:0] LEVEL_RESET   = 2'h3;
	localparam logic [7:0] COMPARE_RESET = 8'd200;
	localparam logic [7:0] MAG_NEG_ZERO  = 8'hff;

	typedef logic [255:0][7:0] rate_table_t;
	typedef logic [3:0][1:0]   gray_table_t;

	// entry 0 is the slowest period, others scale 249/254 of the remaining range
	function automatic rate_table_t build_rate_table();
		rate_table_t t;
		int unsigned p;
		t[0] = 8'hff;
		for (int m = 1; m < 256; m++) begin
			p = (249 * (255 - m)) / 254;
			t[m] = p[7:0];
		end
		return t;
	endfunction

	localparam rate_table_t RATE_TABLE = build_rate_table();

	// phase 0..3 gives pin pattern 1,3,2,0
	localparam gray_table_t GRAY_PATTERN = {2'd0, 2'd2, 2'd3, 2'd1};

	typedef struct packed {
		logic       command;
		logic [2:0] button_bits;
		logic       x_negative;
		logic       y_negative;
		logic [7:0] x_distance;
		logic [7:0] y_distance;
	} item_t;

	typedef struct packed {
		logic       report;
		logic       tick;
		logic       negative;
		logic       down;
		logic [7:0] distance;
	} axis_cmd_t;

endpackage

// ----- rtl/mrq_in_reg.sv -----
// input register stage holding one accepted beat
module mrq_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mrq_pkg::item_t in_item,
	input  logic           advance,
	output logic           valid_s1,
	output mrq_pkg::item_t item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- rtl/mrq_axis.sv -----
// one quadrature axis: step count, rate timer, phase and pin levels
module mrq_axis (
	input  logic                clk,
	input  logic                arst_n,
	input  mrq_pkg::axis_cmd_t  cmd,
	output logic [1:0]          level
);

	logic [7:0] pending_q;
	logic [1:0] phase_q;
	logic       down_q;
	logic [7:0] timer_q;
	logic [7:0] compare_q;
	logic [1:0] level_q;

	logic [7:0] mag;
	logic [7:0] timer_inc;
	logic       hit;

	always_comb begin
		if (!cmd.negative) begin
			mag = cmd.distance;
		end else if (cmd.distance == 8'd0) begin
			mag = mrq_pkg::MAG_NEG_ZERO;
		end else begin
			mag = 8'd0 - cmd.distance;
		end
	end

	assign timer_inc = timer_q + 8'd1;
	assign hit       = timer_inc == compare_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 8'd0;
			phase_q   <= 2'd0;
			down_q    <= 1'b1;
			timer_q   <= 8'd0;
			compare_q <= mrq_pkg::COMPARE_RESET;
			level_q   <= mrq_pkg::LEVEL_RESET;
		end else if (cmd.report) begin
			pending_q <= mag;
			down_q    <= cmd.down;
			compare_q <= mrq_pkg::RATE_TABLE[mag];
		end else if (cmd.tick) begin
			timer_q <= hit ? 8'd0 : timer_inc;
			if (hit && pending_q != 8'd0) begin
				level_q   <= mrq_pkg::GRAY_PATTERN[phase_q];
				phase_q   <= down_q ? phase_q - 2'd1 : phase_q + 2'd1;
				pending_q <= pending_q - 8'd1;
			end
		end
	end

	assign level = level_q;

endmodule

// ----- rtl/mouse_report_to_quadrature_unit.sv -----
// Mouse report to quadrature unit: a report beat (command 0) loads the button
// pin levels (active low) and, per axis, a step count, direction and step period
// from the rate table; a tick beat (command 1) advances each axis timer and emits
// one Gray-code step when it reaches its period and steps remain. Every beat gives
// exactly one result beat with the current pin levels. One beat is accepted per
// cycle while in_ready is high; it passes an input register and is applied to the
// axis state once the result slot is free, and its result is then offered.
`include "assert_macros.svh"

module mouse_report_to_quadrature_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       command,
	input  logic [2:0] button_bits,
	input  logic       x_negative,
	input  logic       y_negative,
	input  logic [7:0] x_distance,
	input  logic [7:0] y_distance,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] button_pins,
	output logic [1:0] horiz_pins,
	output logic [1:0] vert_pins
);

	mrq_pkg::item_t     in_item;
	mrq_pkg::item_t     item_s1;
	mrq_pkg::axis_cmd_t horiz_cmd;
	mrq_pkg::axis_cmd_t vert_cmd;
	logic               valid_s1;
	logic               advance;
	logic               is_report;
	logic               is_tick;
	logic               out_valid_s2;
	logic [2:0]         button_level_q;

	assign in_item = '{
		command:     command,
		button_bits: button_bits,
		x_negative:  x_negative,
		y_negative:  y_negative,
		x_distance:  x_distance,
		y_distance:  y_distance
	};

	// state and result update together, only when the result slot is free
	assign advance   = valid_s1 && (!out_valid_s2 || out_ready);
	assign is_report = advance && item_s1.command == mrq_pkg::CMD_REPORT;
	assign is_tick   = advance && item_s1.command == mrq_pkg::CMD_TICK;

	mrq_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// x negative counts down, y negative counts up
	assign horiz_cmd = '{
		report:   is_report,
		tick:     is_tick,
		negative: item_s1.x_negative,
		down:     item_s1.x_negative,
		distance: item_s1.x_distance
	};
	assign vert_cmd = '{
		report:   is_report,
		tick:     is_tick,
		negative: item_s1.y_negative,
		down:     !item_s1.y_negative,
		distance: item_s1.y_distance
	};

	mrq_axis u_horiz (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (horiz_cmd),
		.level  (horiz_pins)
	);

	mrq_axis u_vert (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (vert_cmd),
		.level  (vert_pins)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_level_q <= mrq_pkg::BUTTON_RESET;
		end else if (is_report) begin
			button_level_q <= ~item_s1.button_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (!out_valid_s2 || out_ready) begin
			out_valid_s2 <= valid_s1;
		end
	end

	assign out_valid   = out_valid_s2;
	assign button_pins = button_level_q;

	// input side stalls only when both stages hold a beat and the output waits
	`MRQ_ASSERT_IMPLIES(a_stall_only_when_full, clk, arst_n, !in_ready, valid_s1 && out_valid_s2 && !out_ready)
	// button levels move only on an applied report
	`MRQ_ASSERT_NEXT(a_buttons_on_report, clk, arst_n, !is_report, $stable(button_pins))
	// quadrature pins move only on an applied tick
	`MRQ_ASSERT_NEXT(a_pins_on_tick, clk, arst_n, !is_tick, $stable(horiz_pins) && $stable(vert_pins))

endmodule
